[sv/stq_pkg.sv]
// Shared types, codes and constants for the sorted timer queue.
package stq_pkg;

  localparam int NUM_TIMERS_DEF = 32;
  localparam int NUM_QUEUES_DEF = 16;
  localparam int MAX_RESULTS    = 32;
  localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
  localparam logic [5:0] TASK_NONE = 6'd32;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_ARM   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_EXPIRY = 2'd1,
    KIND_TASK   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_RUN   = 2'd2
  } slot_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_CHK,
    S_ALLOC_REPLY,
    S_INS_RD,
    S_INS_EV,
    S_INS_LINK,
    S_INS_HEAD,
    S_UNL_RD,
    S_UNL_EV,
    S_TCK_RD,
    S_TCK_EV,
    S_TCK_END,
    S_TCK_FLUSH,
    S_TCK_TS
  } state_e;

  typedef struct packed {
    action_e            action;
    logic [4:0]         slot;
    logic [31:0]        delay_ticks;
    logic signed [31:0] payload;
    logic [3:0]         queue_id;
  } in_req_t;

  typedef struct packed {
    kind_e              kind;
    logic [4:0]         slot_out;
    logic               alloc_ok;
    logic signed [31:0] payload_out;
    logic [3:0]         queue_out;
    logic               last;
  } out_rsp_t;

  typedef struct packed {
    logic accept;
    logic scan_next;
    logic alloc_reply;
    logic mem_rd;
    logic walk_adv;
    logic ins_link;
    logic ins_head;
    logic unl_fix;
    logic tck_take;
    logic tck_head;
    logic flush;
    logic push_ts;
  } cmd_t;

  typedef struct packed {
    action_e in_action;
    logic    arm_go;
    logic    free_run;
    logic    scan_free;
    logic    scan_last;
    logic    cur_none;
    logic    cur_is_slot;
    logic    ins_here;
    logic    due;
    logic    cur_is_task;
    logic    cap_hit;
    logic    pend_valid;
    logic    ts;
    logic    out_free;
  } sts_t;

endpackage

[sv/stq_ctrl.sv]
// Controller state machine for the sorted timer queue.
module stq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  stq_pkg::sts_t     sts_i,
  output stq_pkg::cmd_t     cmd_o
);

  stq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != stq_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      stq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (sts_i.in_action)
            stq_pkg::ACT_TICK:  state_d = stq_pkg::S_TCK_RD;
            stq_pkg::ACT_ALLOC: state_d = stq_pkg::S_ALLOC_CHK;
            stq_pkg::ACT_FREE:  state_d = sts_i.free_run ? stq_pkg::S_UNL_RD : stq_pkg::S_IDLE;
            stq_pkg::ACT_ARM:   state_d = sts_i.arm_go ? stq_pkg::S_INS_RD : stq_pkg::S_IDLE;
            default:            state_d = stq_pkg::S_IDLE;
          endcase
        end
      end
      stq_pkg::S_ALLOC_CHK: begin
        if (sts_i.scan_free || sts_i.scan_last) begin
          state_d = stq_pkg::S_ALLOC_REPLY;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      stq_pkg::S_ALLOC_REPLY: begin
        if (sts_i.out_free) begin
          cmd_o.alloc_reply = 1'b1;
          state_d = stq_pkg::S_IDLE;
        end
      end
      stq_pkg::S_INS_RD: begin
        if (sts_i.cur_none) begin
          state_d = stq_pkg::S_INS_LINK;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = stq_pkg::S_INS_EV;
        end
      end
      stq_pkg::S_INS_EV: begin
        if (sts_i.ins_here) begin
          state_d = stq_pkg::S_INS_LINK;
        end else begin
          cmd_o.walk_adv = 1'b1;
          state_d = stq_pkg::S_INS_RD;
        end
      end
      stq_pkg::S_INS_LINK: begin
        cmd_o.ins_link = 1'b1;
        state_d = stq_pkg::S_INS_HEAD;
      end
      stq_pkg::S_INS_HEAD: begin
        cmd_o.ins_head = 1'b1;
        state_d = stq_pkg::S_IDLE;
      end
      stq_pkg::S_UNL_RD: begin
        if (sts_i.cur_none) begin
          state_d = stq_pkg::S_IDLE;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = stq_pkg::S_UNL_EV;
        end
      end
      stq_pkg::S_UNL_EV: begin
        if (sts_i.cur_is_slot) begin
          cmd_o.unl_fix = 1'b1;
          state_d = stq_pkg::S_IDLE;
        end else begin
          cmd_o.walk_adv = 1'b1;
          state_d = stq_pkg::S_UNL_RD;
        end
      end
      stq_pkg::S_TCK_RD: begin
        if (sts_i.cur_none || sts_i.cap_hit) begin
          state_d = stq_pkg::S_TCK_END;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = stq_pkg::S_TCK_EV;
        end
      end
      stq_pkg::S_TCK_EV: begin
        if (!sts_i.due) begin
          state_d = stq_pkg::S_TCK_END;
        end else if (sts_i.cur_is_task || !sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.tck_take = 1'b1;
          state_d = stq_pkg::S_TCK_RD;
        end
      end
      stq_pkg::S_TCK_END: begin
        cmd_o.tck_head = 1'b1;
        state_d = stq_pkg::S_TCK_FLUSH;
      end
      stq_pkg::S_TCK_FLUSH: begin
        if (!sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.flush = sts_i.pend_valid;
          state_d = sts_i.ts ? stq_pkg::S_TCK_TS : stq_pkg::S_IDLE;
        end
      end
      stq_pkg::S_TCK_TS: begin
        if (sts_i.out_free) begin
          cmd_o.push_ts = 1'b1;
          state_d = stq_pkg::S_IDLE;
        end
      end
      default: state_d = stq_pkg::S_IDLE;
    endcase
  end

endmodule

[sv/stq_dp.sv]
// Datapath of the sorted timer queue: slot stores, list pointers and result register.
module stq_dp #(
  parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF,
  parameter int NUM_QUEUES = stq_pkg::NUM_QUEUES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_wdata_i,
  input  stq_pkg::in_req_t  in_req_i,
  input  logic              out_stall_i,
  input  stq_pkg::cmd_t     cmd_i,
  output stq_pkg::sts_t     sts_o,
  output logic              out_valid_o,
  output stq_pkg::out_rsp_t out_rsp_o
);

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int PW = $clog2(NUM_TIMERS + 1);
  localparam logic [PW-1:0] NONE = PW'(NUM_TIMERS);

  logic [31:0]               count_q;
  logic [PW-1:0]             head_q, cur_q, prev_q;
  logic [5:0]                task_q;
  stq_pkg::slot_state_e      status_q [NUM_TIMERS];
  logic [IW-1:0]             scan_q, req_slot_q;
  logic [31:0]               new_dl_q;
  logic [stq_pkg::CNT_W-1:0] cnt_q;
  logic                      ts_q, pend_valid_q, out_valid_q;
  logic [4:0]                pend_slot_q;
  logic signed [31:0]        pend_pay_q;
  logic [3:0]                pend_queue_q;
  logic [31:0]               rd_dl_q;
  logic [PW-1:0]             rd_link_q;
  logic signed [31:0]        rd_pay_q;
  logic [3:0]                rd_queue_q;
  stq_pkg::out_rsp_t         out_q, push_rsp;

  logic [31:0]               dl_mem    [NUM_TIMERS];
  logic [PW-1:0]             link_mem  [NUM_TIMERS];
  logic signed [31:0]        pay_mem   [NUM_TIMERS];
  logic [3:0]                queue_mem [NUM_TIMERS];

  logic          in_ok, push, pend_push, prev_none, link_we;
  logic [IW-1:0] in_idx, cur_idx, prev_idx, link_wa;
  logic [PW-1:0] link_wd;
  logic [3:0]    in_queue;
  stq_pkg::slot_state_e in_status;

  assign in_ok     = int'(in_req_i.slot) < NUM_TIMERS;
  assign in_idx    = IW'(in_req_i.slot);
  assign in_status = status_q[in_idx];
  assign in_queue  = (int'(in_req_i.queue_id) >= NUM_QUEUES) ? 4'(NUM_QUEUES - 1)
                                                              : in_req_i.queue_id;
  assign cur_idx   = cur_q[IW-1:0];
  assign prev_idx  = prev_q[IW-1:0];
  assign prev_none = (prev_q == NONE);

  always_comb begin
    sts_o.in_action   = in_req_i.action;
    sts_o.arm_go      = in_ok && (in_status != stq_pkg::ST_RUN);
    sts_o.free_run    = in_ok && (in_status == stq_pkg::ST_RUN);
    sts_o.scan_free   = (status_q[scan_q] == stq_pkg::ST_FREE);
    sts_o.scan_last   = (scan_q == IW'(NUM_TIMERS - 1));
    sts_o.cur_none    = (cur_q == NONE);
    sts_o.cur_is_slot = (cur_q == PW'(req_slot_q));
    sts_o.ins_here    = (new_dl_q <= rd_dl_q);
    sts_o.due         = (rd_dl_q <= count_q);
    sts_o.cur_is_task = (7'(cur_q) == 7'(task_q));
    sts_o.cap_hit     = (cnt_q >= stq_pkg::CNT_W'(stq_pkg::MAX_RESULTS));
    sts_o.pend_valid  = pend_valid_q;
    sts_o.ts          = ts_q;
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  // Result to load into the output register this cycle.
  assign pend_push = cmd_i.tck_take && !sts_o.cur_is_task && pend_valid_q;
  assign push      = cmd_i.alloc_reply || cmd_i.flush || cmd_i.push_ts || pend_push;

  always_comb begin
    push_rsp = '0;
    if (cmd_i.alloc_reply) begin
      push_rsp.kind     = stq_pkg::KIND_ALLOC;
      push_rsp.slot_out = sts_o.scan_free ? 5'(scan_q) : 5'd0;
      push_rsp.alloc_ok = sts_o.scan_free;
      push_rsp.last     = 1'b1;
    end else if (cmd_i.push_ts) begin
      push_rsp.kind     = stq_pkg::KIND_TASK;
      push_rsp.slot_out = task_q[4:0];
      push_rsp.last     = 1'b1;
    end else begin
      push_rsp.kind        = stq_pkg::KIND_EXPIRY;
      push_rsp.slot_out    = pend_slot_q;
      push_rsp.payload_out = pend_pay_q;
      push_rsp.queue_out   = pend_queue_q;
      push_rsp.last        = cmd_i.flush && !ts_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      head_q       <= NONE;
      cur_q        <= NONE;
      prev_q       <= NONE;
      task_q       <= stq_pkg::TASK_NONE;
      scan_q       <= '0;
      cnt_q        <= '0;
      ts_q         <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        status_q[i] <= stq_pkg::ST_FREE;
      end
    end else begin
      if (cfg_we_i) begin
        task_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        cur_q  <= head_q;
        prev_q <= NONE;
        cnt_q  <= '0;
        ts_q   <= 1'b0;
        scan_q <= '0;
        case (in_req_i.action)
          stq_pkg::ACT_TICK: count_q <= count_q + 32'd1;
          stq_pkg::ACT_FREE: if (in_ok) status_q[in_idx] <= stq_pkg::ST_FREE;
          stq_pkg::ACT_ARM:  if (sts_o.arm_go) status_q[in_idx] <= stq_pkg::ST_RUN;
          default: ;
        endcase
      end
      if (cmd_i.scan_next) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.alloc_reply && sts_o.scan_free) begin
        status_q[scan_q] <= stq_pkg::ST_ALLOC;
      end
      if (cmd_i.walk_adv) begin
        prev_q <= cur_q;
        cur_q  <= rd_link_q;
      end
      if (cmd_i.ins_head && prev_none) begin
        head_q <= PW'(req_slot_q);
      end
      if (cmd_i.unl_fix && prev_none) begin
        head_q <= rd_link_q;
      end
      if (cmd_i.tck_take) begin
        status_q[cur_idx] <= stq_pkg::ST_ALLOC;
        cur_q <= rd_link_q;
        cnt_q <= cnt_q + 1'b1;
        if (sts_o.cur_is_task) begin
          ts_q <= 1'b1;
        end else begin
          pend_valid_q <= 1'b1;
        end
      end
      if (cmd_i.tck_head) begin
        head_q <= cur_q;
      end
      if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Link store takes one write a cycle.
  always_comb begin
    link_we = 1'b0;
    link_wa = req_slot_q;
    link_wd = cur_q;
    if (cmd_i.ins_link) begin
      link_we = 1'b1;
    end else if (cmd_i.ins_head && !prev_none) begin
      link_we = 1'b1;
      link_wa = prev_idx;
      link_wd = PW'(req_slot_q);
    end else if (cmd_i.unl_fix && !prev_none) begin
      link_we = 1'b1;
      link_wa = prev_idx;
      link_wd = rd_link_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_slot_q <= in_idx;
      new_dl_q   <= count_q + in_req_i.delay_ticks;
      if ((in_req_i.action == stq_pkg::ACT_ARM) && sts_o.arm_go) begin
        dl_mem[in_idx]    <= count_q + in_req_i.delay_ticks;
        pay_mem[in_idx]   <= in_req_i.payload;
        queue_mem[in_idx] <= in_queue;
      end
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (cmd_i.mem_rd) begin
      rd_dl_q    <= dl_mem[cur_idx];
      rd_link_q  <= link_mem[cur_idx];
      rd_pay_q   <= pay_mem[cur_idx];
      rd_queue_q <= queue_mem[cur_idx];
    end
    if (cmd_i.tck_take && !sts_o.cur_is_task) begin
      pend_slot_q  <= 5'(cur_q);
      pend_pay_q   <= rd_pay_q;
      pend_queue_q <= rd_queue_q;
    end
    if (push) begin
      out_q <= push_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

[sv/sorted_timer_queue.sv]
// Top level of the sorted timer queue: controller, datapath and checks.
//
// Use: requests arrive on in_valid_i/in_req_i and are taken at a clock edge
// with in_valid_i high and in_stall_o low. Actions: tick, allocate, free, arm.
// Results leave on out_valid_o/out_rsp_o and are taken when out_stall_i is low.
// One request is worked on at a time; in_stall_o is high from acceptance until
// the request's work is done.
// Steps: free or arm with nothing to do goes straight back to idle; allocate
// scans up to NUM_TIMERS slots for a free one, then replies; arm walks the list
// comparing entries, then links the new entry in; free of a running timer walks
// up to and including the slot and unlinks it; tick reads entries while due,
// up to the list end or the result cap, then sets the head, flushes and pushes
// any task switch. The walk reads one entry at a time through the single read
// port of the slot stores. Each expiry is held one step in a pending register
// and pushed out by the next due non-task entry or at the end of the walk.
// A single output register holds the finished result; new results wait while
// the receiver stalls, and the list walk holds where a result cannot leave.
// Reset: count 0, list empty, all slots free, task timer none (32). Slot
// stores need no clearing pass: they are read only for running timers.
module sorted_timer_queue #(
  parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF,
  parameter int NUM_QUEUES = stq_pkg::NUM_QUEUES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  stq_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output stq_pkg::out_rsp_t out_rsp_o
);

  stq_pkg::cmd_t cmd;
  stq_pkg::sts_t sts;

  // Sequencing of each request's steps.
  stq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Stores, list pointers, pending expiry and the output register.
  stq_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

  // No held expiry may remain once the block is ready for a new request.
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !sts.pend_valid)
    else $error("pending expiry left behind at idle");

  // At most one result is pushed per cycle.
  a_one_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.alloc_reply, cmd.flush, cmd.push_ts}))
    else $error("two results pushed in one cycle");

  // A result is only pushed when the output register can take it.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.alloc_reply || cmd.flush || cmd.push_ts) |-> sts.out_free)
    else $error("result pushed over a stalled result");

endmodule
